@@ rtl/crc_pkg.sv @@
// Package for the coordinate rank compressor.
// Holds the request and response word types and the sequencer state type.
// No dependencies.
package crc_pkg;

   typedef struct packed {
      logic signed [30:0] coord_value;
      logic               last_value;
   } req_type;

   typedef struct packed {
      logic [6:0] rank_doubled;
      logic [7:0] span_doubled;
      logic       overflow;
      logic       last_result;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FETCH,
      ST_GRAB,
      ST_SCAN
   } state_type;

endpackage

@@ rtl/coordinate_rank_compressor.sv @@
// Top level of the coordinate rank compressor.
// Depends on crc_pkg for word types and sequencer states.
//
// Usage: drive req_data with start high while busy is low; each such cycle
// loads one word. Values beyond MAX_VALUES are dropped and flagged. The word
// with last_value set ends the run: busy rises and the block ranks the run.
// Pass one marks the first occurrence of each value: entry i scans entries
// 0..i-1. Pass two ranks each entry against all marked entries and emits
// one response word per entry in arrival order, each on rsp_data for one
// cycle with rsp_valid high, the cycle after its scan ends. The time a run
// takes after its last word is set by the single read port of the value
// memory, which is read one entry per cycle. The final response carries
// last_result; busy drops in the same cycle and a new run may start.
// The receiver cannot stall: responses must be taken when shown.
// Reset (synchronous, active high) clears the count, the overflow flag and
// the sequencer; the memories are not cleared and need not be.
module coordinate_rank_compressor #(
   parameter int MAX_VALUES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  crc_pkg::req_type req_data,
   output logic             rsp_valid,
   output crc_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
   localparam int CW = $clog2(MAX_VALUES + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_VALUES);

   logic signed [30:0] val_mem [MAX_VALUES];
   logic               flag_mem [MAX_VALUES];
   logic signed [30:0] val_rd_ff;
   logic               flag_rd_ff;

   crc_pkg::state_type state_ff, state_in;
   logic          pass_ff, pass_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic          pend_ff, pend_in;
   logic          ovf_ff, ovf_in;
   logic signed [30:0] vi_ff, vi_in;
   logic          rsp_v_ff, rsp_v_in;
   crc_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] raddr;
   logic          val_we;
   logic          flag_we;
   logic          flag_wd;
   logic [CW-1:0] lim;
   logic          hit;
   logic [CW-1:0] n_next;
   logic [CW:0]   rank_x2;
   logic [CW:0]   span_x2;

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[cnt_ff[AW-1:0]] <= req_data.coord_value;
      end
      if (flag_we) begin
         flag_mem[i_ff[AW-1:0]] <= flag_wd;
      end
      val_rd_ff  <= val_mem[raddr];
      flag_rd_ff <= flag_mem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      ovf_in   = ovf_ff;
      vi_in    = vi_ff;
      rsp_v_in = 1'b0;
      rsp_in   = rsp_ff;
      raddr    = i_ff[AW-1:0];
      val_we   = 1'b0;
      flag_we  = 1'b0;
      flag_wd  = 1'b0;
      lim      = pass_ff ? cnt_ff : i_ff;
      hit      = 1'b0;
      n_next   = n_ff;
      rank_x2  = '0;
      span_x2  = '0;
      unique case (state_ff)
         crc_pkg::ST_LOAD: begin
            if (start) begin
               if (cnt_ff < MAXC) begin
                  val_we = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_value) begin
                  state_in = crc_pkg::ST_FETCH;
                  pass_in  = 1'b0;
                  i_in     = '0;
                  n_in     = '0;
               end
            end
         end
         crc_pkg::ST_FETCH: begin
            raddr    = i_ff[AW-1:0];
            state_in = crc_pkg::ST_GRAB;
         end
         crc_pkg::ST_GRAB: begin
            vi_in    = val_rd_ff;
            j_in     = '0;
            acc_in   = '0;
            state_in = crc_pkg::ST_SCAN;
         end
         crc_pkg::ST_SCAN: begin
            if (pend_ff) begin
               hit = pass_ff ? (flag_rd_ff && (val_rd_ff < vi_ff))
                             : (val_rd_ff == vi_ff);
               if (hit) begin
                  acc_in = acc_ff + CW'(1);
               end
            end
            if (j_ff < lim) begin
               raddr   = j_ff[AW-1:0];
               pend_in = 1'b1;
               j_in    = j_ff + CW'(1);
            end else if (!pend_ff) begin
               i_in = i_ff + CW'(1);
               if (!pass_ff) begin
                  flag_we = 1'b1;
                  flag_wd = (acc_ff == '0);
                  n_next  = n_ff + ((acc_ff == '0) ? CW'(1) : CW'(0));
                  n_in    = n_next;
                  if (i_ff + CW'(1) == cnt_ff) begin
                     pass_in = 1'b1;
                     i_in    = '0;
                  end
                  state_in = crc_pkg::ST_FETCH;
               end else begin
                  rank_x2             = {acc_ff, 1'b0};
                  span_x2             = {n_ff, 1'b0};
                  rsp_v_in            = 1'b1;
                  rsp_in.rank_doubled = rank_x2[6:0];
                  rsp_in.span_doubled = span_x2[7:0];
                  rsp_in.overflow     = ovf_ff;
                  rsp_in.last_result  = (i_ff + CW'(1) == cnt_ff);
                  if (i_ff + CW'(1) == cnt_ff) begin
                     state_in = crc_pkg::ST_LOAD;
                     cnt_in   = '0;
                     ovf_in   = 1'b0;
                  end else begin
                     state_in = crc_pkg::ST_FETCH;
                  end
               end
            end
         end
         default: begin
            state_in = crc_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc_pkg::ST_LOAD;
         pass_ff  <= 1'b0;
         cnt_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= '0;
         acc_ff   <= '0;
         pend_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         n_ff     <= n_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         ovf_ff   <= ovf_in;
         rsp_v_ff <= rsp_v_in;
      end
      vi_ff  <= vi_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != crc_pkg::ST_LOAD);
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= MAXC) else $error("load count above capacity");
   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == crc_pkg::ST_SCAN)) else $error("read pending outside scan");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_result) |-> !busy) else $error("busy after final word");
   a_emit_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_v_in |-> pass_ff) else $error("response outside ranking pass");
`endif

endmodule

@@ bench/coordinate_rank_compressor_tb.sv @@
// Testbench for the coordinate rank compressor: loads runs of signed values,
// predicts ranks and spans per run, and checks every response word in order.
// Depends on crc_pkg and the coordinate_rank_compressor RTL.
`timescale 1ns / 1ps

module coordinate_rank_compressor_tb;

   localparam int CAPACITY = 64;
   localparam int CYCLE_LIMIT = 3000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   crc_pkg::req_type req_data = '0;
   logic    rsp_valid;
   crc_pkg::rsp_type rsp_data;

   coordinate_rank_compressor #(.MAX_VALUES(CAPACITY)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   crc_pkg::req_type pending_words[$];
   crc_pkg::rsp_type expected_ranks[$];
   logic signed [30:0] run_values[$];
   logic overflow_pending = 1'b0;
   int mismatches = 0;
   int words_checked = 0;
   int runs_sent = 0;
   int cycle_count = 0;
   int quiet_from = 0;
   bit stimulus_done = 1'b0;
   bit word_taken = 1'b0;

   // predict the response words for one accepted request word
   task automatic predict_word(crc_pkg::req_type w);
      logic signed [30:0] distinct[$];
      int rank;
      crc_pkg::rsp_type r;
      if (run_values.size() < CAPACITY) run_values.push_back(w.coord_value);
      else overflow_pending = 1'b1;
      if (w.last_value) begin
         foreach (run_values[i]) begin
            rank = 0;
            foreach (distinct[j]) if (distinct[j] == run_values[i]) rank = 1;
            if (rank == 0) distinct.push_back(run_values[i]);
         end
         foreach (run_values[i]) begin
            rank = 0;
            foreach (distinct[j]) if (distinct[j] < run_values[i]) rank++;
            r.rank_doubled = 7'(rank * 2);
            r.span_doubled = 8'(distinct.size() * 2);
            r.overflow = overflow_pending;
            r.last_result = (i == run_values.size() - 1);
            expected_ranks.push_back(r);
         end
         run_values.delete();
         overflow_pending = 1'b0;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         // previous word taken at the rising edge just past, or idle
         if (pending_words.size() > 0 && ($urandom_range(99) >= 13 ||
               (cycle_count >= quiet_from && cycle_count < quiet_from + 400))) begin
            req_data <= pending_words.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      word_taken = !reset && start && !busy;
      if (word_taken) predict_word(req_data);
      if (!reset && rsp_valid) begin
         if (expected_ranks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", rsp_data);
         end else begin
            if (rsp_data !== expected_ranks[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", expected_ranks[0], rsp_data);
            end
            void'(expected_ranks.pop_front());
            words_checked++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("coordinate_rank_compressor test failed");
         $finish;
      end
   end

   function automatic logic signed [30:0] pick_value(int pool);
      case ($urandom_range(9))
         0: return 31'sh3FFFFFFF;
         1: return 31'sh40000000;
         2: return 31'($urandom);
         default: return 31'($urandom_range(pool)) - 31'(pool / 2);
      endcase
   endfunction

   task automatic queue_run(int len, int pool);
      crc_pkg::req_type w;
      for (int i = 0; i < len; i++) begin
         w.coord_value = pick_value(pool);
         w.last_value = (i == len - 1);
         pending_words.push_back(w);
      end
      runs_sent++;
   endtask

   initial begin
      crc_pkg::req_type w;
      int total;
      quiet_from = 2000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed: single value, extremes, duplicates
      w = '{31'sh40000000, 1'b1}; pending_words.push_back(w);
      w = '{31'sh3FFFFFFF, 1'b0}; pending_words.push_back(w);
      w = '{31'sh40000000, 1'b0}; pending_words.push_back(w);
      w = '{31'sh0, 1'b0};        pending_words.push_back(w);
      w = '{31'sh3FFFFFFF, 1'b1}; pending_words.push_back(w);
      w = '{-31'sd7, 1'b0};       pending_words.push_back(w);
      w = '{-31'sd7, 1'b1};       pending_words.push_back(w);
      runs_sent = 3;
      // overflow: capacity plus extra, last dropped
      queue_run(CAPACITY + 3, 1000);
      total = CAPACITY + 10;
      while (total < 310) begin
         int len;
         len = ($urandom_range(9) == 0) ? $urandom_range(CAPACITY + 4, 40)
                                        : $urandom_range(12, 1);
         queue_run(len, $urandom_range(1) ? 8 : 2000000000);
         total += len;
      end
      wait (pending_words.size() == 0 && !start);
      wait (expected_ranks.size() == 0);
      repeat (20) @(posedge clock);
      $display("ran %0d runs, checked %0d response words, %0d mismatches",
               runs_sent, words_checked, mismatches);
      if (mismatches == 0 && expected_ranks.size() == 0 && run_values.size() == 0)
         $display("coordinate_rank_compressor test passed");
      else
         $display("coordinate_rank_compressor test failed");
      $finish;
   end
endmodule
